// ----- src/lje_pkg.sv -----
package lje_pkg;

  // Configuration register indices
  localparam logic [2:0] REG_BOX_X        = 3'd0;
  localparam logic [2:0] REG_BOX_Y        = 3'd1;
  localparam logic [2:0] REG_BOX_Z        = 3'd2;
  localparam logic [2:0] REG_CUTOFF       = 3'd3;
  localparam logic [2:0] REG_SIGMA_SQ     = 3'd4;
  localparam logic [2:0] REG_EPSILON      = 3'd5;
  localparam logic [2:0] REG_ENERGY_SHIFT = 3'd6;
  localparam logic [2:0] REG_LINEAR_SLOPE = 3'd7;

  // Reset values
  localparam logic [62:0] SIGMA_SQ_RESET = 63'h0000_0001_0000_0000;
  localparam logic [31:0] EPSILON_RESET  = 32'h0001_0000;

  typedef struct packed {
    logic [30:0]        box_x;
    logic [30:0]        box_y;
    logic [30:0]        box_z;
    logic [30:0]        cutoff;
    logic [62:0]        sigma_sq;
    logic [31:0]        epsilon;
    logic signed [47:0] energy_shift;
    logic signed [31:0] linear_slope;
  } cfg_t;

  // Pair request between front and back
  typedef struct packed {
    logic [63:0] r2;
    logic        ok;
    logic        last;
  } pair_t;

  // Result request
  typedef struct packed {
    logic [47:0] energy_sum;
    logic        saturated;
  } result_t;

endpackage

// ----- src/lje_fifo.sv -----
module lje_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ----- src/lje_front.sv -----
module lje_front (
  input  logic                clk,
  input  logic                rst,
  input  lje_pkg::cfg_t       cfg,
  input  logic                push,
  output logic                full,
  input  logic signed [31:0]  ref_x,
  input  logic signed [31:0]  ref_y,
  input  logic signed [31:0]  ref_z,
  input  logic signed [31:0]  other_x,
  input  logic signed [31:0]  other_y,
  input  logic signed [31:0]  other_z,
  input  logic                same_molecule,
  input  logic                last_pair,
  output logic                q_wr,
  output lje_pkg::pair_t      q_data,
  input  logic                q_full
);
  import lje_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SQR  = 2'd1;
  localparam logic [1:0] F_SUM  = 2'd2;

  localparam logic signed [35:0] LIM = 36'sh0_8000_0000;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [30:0] ax, ay, az;
  logic        ok, last;
  logic [61:0] sx, sy, sz;

  logic signed [35:0] dx, dy, dz;
  logic in_box;

  // minimum image on one axis, one wrap at most
  function automatic logic signed [35:0] wrap_axis(input logic signed [35:0] d_in,
                                                  input logic [30:0] len);
    logic signed [35:0] d;
    logic signed [35:0] l;
    d = d_in;
    l = $signed({5'b0, len});
    if (len != '0) begin
      if ((d <<< 1) > l) d = d - l;
      if ((d <<< 1) < -l) d = d + l;
    end
    return d;
  endfunction

  function automatic logic [30:0] mag31(input logic signed [35:0] d);
    logic signed [35:0] a;
    a = (d < 0) ? -d : d;
    return a[30:0];
  endfunction

  // separations, wrapped
  always_comb begin
    dx = wrap_axis(36'(ref_x) - 36'(other_x), cfg.box_x);
    dy = wrap_axis(36'(ref_y) - 36'(other_y), cfg.box_y);
    dz = wrap_axis(36'(ref_z) - 36'(other_z), cfg.box_z);
    in_box = (dx < LIM) && (dx > -LIM) && (dy < LIM) && (dy > -LIM)
          && (dz < LIM) && (dz > -LIM);
  end

  assign full   = (state != F_IDLE);
  assign q_wr   = (state == F_SUM);
  assign q_data = '{r2: 64'(sx) + 64'(sy) + 64'(sz), ok: ok, last: last};

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (push) state_next = F_SQR;
      F_SQR:  state_next = F_SUM;
      F_SUM:  if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // payload: capture, then square
  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      ax   <= mag31(dx);
      ay   <= mag31(dy);
      az   <= mag31(dz);
      ok   <= !same_molecule && in_box;
      last <= last_pair;
    end
    if (state == F_SQR) begin
      sx <= ax * ax;
      sy <= ay * ay;
      sz <= az * az;
    end
  end
endmodule

// ----- src/lje_back.sv -----
module lje_back (
  input  logic              clk,
  input  logic              rst,
  input  lje_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  lje_pkg::pair_t    q_data,
  output logic              q_rd,
  output logic              o_wr,
  output lje_pkg::result_t  o_data,
  input  logic              o_full
);
  import lje_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CUT   = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_ITER  = 4'd3;
  localparam logic [3:0] S_MPREP = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_MPOST = 4'd6;
  localparam logic [3:0] S_LIN   = 4'd7;
  localparam logic [3:0] S_LIN2  = 4'd8;
  localparam logic [3:0] S_SUM   = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  localparam logic [1:0] OP_S4 = 2'd0;
  localparam logic [1:0] OP_S6 = 2'd1;
  localparam logic [1:0] OP_P  = 2'd2;
  localparam logic [1:0] OP_T  = 2'd3;

  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
  localparam logic [63:0] ONE40 = 64'h0000_0100_0000_0000;
  localparam logic [63:0] MAX48U = 64'h0000_7FFF_FFFF_FFFF;

  logic [3:0] state;

  logic [63:0] r2;
  logic        ok, last;
  logic [61:0] cut2;

  // divider and square root
  logic [63:0] drem, dlo, dq;
  logic        div_on;
  logic [63:0] sq_v;
  logic [33:0] sq_rem;
  logic [31:0] sq_root;
  logic [5:0]  cnt;

  // shared multiplier
  logic [63:0]  ma, mb, pp;
  logic [127:0] macc;
  logic [2:0]   mcnt;
  logic [1:0]   mop;
  logic         pos;

  logic [63:0] lmag;
  logic        lneg;

  logic signed [47:0] lj, lin, term, acc;
  logic        sat;

  logic [64:0] d_sh;
  logic [35:0] s_rem2;
  logic [35:0] s_trial;
  logic [31:0] a_half, b_half;
  logic [1:0]  prev;
  logic [63:0] s6;
  logic [63:0] v;
  logic [55:0] lmag_s;
  logic signed [33:0] diff;
  logic [33:0] absd;
  logic [31:0] abss;
  logic [48:0] sum_sat, acc_sat;

  // clamp to 48 bits, flag in top bit
  function automatic logic [48:0] sat48(input logic signed [49:0] x);
    if (x > 50'(MAX48)) return {1'b1, MAX48};
    if (x < 50'(MIN48)) return {1'b1, MIN48};
    return {1'b0, x[47:0]};
  endfunction

  assign q_rd   = (state == S_IDLE) && !q_empty;
  assign o_wr   = (state == S_DONE) && last;
  assign o_data = '{energy_sum: acc, saturated: sat};

  // datapath helpers
  always_comb begin
    d_sh    = {drem, dlo[63]};
    s_rem2  = {sq_rem, sq_v[63:62]};
    s_trial = {2'b0, sq_root, 2'b01};
    a_half  = mcnt[0] ? ma[63:32] : ma[31:0];
    b_half  = mcnt[1] ? mb[63:32] : mb[31:0];
    prev    = 2'(mcnt - 3'd1);
    s6      = macc[119:56];
    v       = macc[77:14];
    lmag_s  = lmag[63:8];
    diff    = $signed({2'b0, sq_root}) - $signed({3'b0, cfg.cutoff});
    absd    = (diff < 0) ? 34'(-diff) : 34'(diff);
    abss    = (cfg.linear_slope < 0) ? 32'(-cfg.linear_slope)
                                     : 32'(cfg.linear_slope);
    sum_sat = sat48(50'(lj) + 50'(cfg.energy_shift) + 50'(lin));
    acc_sat = sat48(50'(acc) + 50'(term));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc   <= '0;
      sat   <= 1'b0;
      cnt   <= '0;
      mcnt  <= '0;
      mop   <= OP_S4;
    end else begin
      unique case (state)
        // take the next pair
        S_IDLE: begin
          if (!q_empty) begin
            r2    <= q_data.r2;
            ok    <= q_data.ok;
            last  <= q_data.last;
            state <= S_CUT;
          end
        end
        S_CUT: begin
          cut2  <= cfg.cutoff * cfg.cutoff;
          state <= S_CHK;
        end
        // cutoff test and set-up of divider and root
        S_CHK: begin
          sq_v    <= r2;
          sq_rem  <= '0;
          sq_root <= '0;
          cnt     <= '0;
          drem    <= {9'b0, cfg.sigma_sq[62:8]};
          dlo     <= {cfg.sigma_sq[7:0], 56'b0};
          dq      <= '0;
          div_on  <= 1'b0;
          if (!ok || r2 >= {2'b0, cut2}) begin
            state <= S_DONE;
          end else begin
            state <= S_ITER;
            if (cfg.epsilon == '0) begin
              lj <= '0;
            end else if ({9'b0, cfg.sigma_sq[62:8]} >= r2) begin
              lj  <= MAX48;
              sat <= 1'b1;
            end else begin
              div_on <= 1'b1;
            end
          end
        end
        // one quotient bit and, until all 32 root bits are done, one root bit per cycle
        S_ITER: begin
          dlo <= {dlo[62:0], 1'b0};
          if (d_sh >= {1'b0, r2}) begin
            drem <= 64'(d_sh - {1'b0, r2});
            dq   <= {dq[62:0], 1'b1};
          end else begin
            drem <= d_sh[63:0];
            dq   <= {dq[62:0], 1'b0};
          end
          if (cnt < 6'd32) begin
            sq_v <= {sq_v[61:0], 2'b0};
            if (s_rem2 >= s_trial) begin
              sq_rem  <= 34'(s_rem2 - s_trial);
              sq_root <= {sq_root[30:0], 1'b1};
            end else begin
              sq_rem  <= s_rem2[33:0];
              sq_root <= {sq_root[30:0], 1'b0};
            end
          end
          cnt <= cnt + 1'b1;
          if (!div_on && cnt == 6'd31) begin
            state <= S_LIN;
          end else if (cnt == 6'd63) begin
            state <= S_MPREP;
          end
        end
        S_MPREP: begin
          ma    <= dq;
          mb    <= dq;
          mop   <= OP_S4;
          mcnt  <= '0;
          state <= S_MUL;
        end
        // 64x64 product from four 32x32 partial products
        S_MUL: begin
          if (mcnt != 3'd4) begin
            pp <= a_half * b_half;
          end
          if (mcnt == 3'd0) begin
            macc <= '0;
          end else begin
            unique case (prev)
              2'd0: macc <= macc + {64'b0, pp};
              2'd1, 2'd2: macc <= macc + {32'b0, pp, 32'b0};
              2'd3: macc <= macc + {pp, 64'b0};
              default: macc <= macc;
            endcase
          end
          if (mcnt == 3'd4) begin
            mcnt  <= '0;
            state <= S_MPOST;
          end else begin
            mcnt <= mcnt + 1'b1;
          end
        end
        // scale each product and set up the next multiply or finish the LJ term
        S_MPOST: begin
          unique case (mop)
            OP_S4: begin
              ma    <= {8'b0, macc[127:72]};
              mb    <= dq;
              mop   <= OP_S6;
              state <= S_MUL;
            end
            OP_S6: begin
              pos   <= (s6 >= ONE40);
              ma    <= s6;
              mb    <= (s6 >= ONE40) ? s6 - ONE40 : ONE40 - s6;
              mop   <= OP_P;
              state <= S_MUL;
            end
            OP_P: begin
              if (macc[127:120] != '0) begin
                lj    <= pos ? MAX48 : MIN48;
                sat   <= 1'b1;
                state <= S_LIN;
              end else begin
                ma    <= macc[119:56];
                mb    <= {32'b0, cfg.epsilon};
                mop   <= OP_T;
                state <= S_MUL;
              end
            end
            OP_T: begin
              state <= S_LIN;
              if (macc[127:78] != '0) begin
                lj  <= pos ? MAX48 : MIN48;
                sat <= 1'b1;
              end else if (pos) begin
                if (v > MAX48U) begin
                  lj  <= MAX48;
                  sat <= 1'b1;
                end else begin
                  lj <= $signed(v[47:0]);
                end
              end else begin
                if (v > MAX48U + 64'd1) begin
                  lj  <= MIN48;
                  sat <= 1'b1;
                end else begin
                  lj <= -$signed(v[47:0]);
                end
              end
            end
            default: state <= S_LIN;
          endcase
        end
        // linear shift term
        S_LIN: begin
          lmag  <= abss * absd[31:0];
          lneg  <= (cfg.linear_slope < 0) != (diff < 0);
          state <= S_LIN2;
        end
        S_LIN2: begin
          state <= S_SUM;
          if (cfg.linear_slope == '0) begin
            lin <= '0;
          end else if (!lneg) begin
            if (64'(lmag_s) > MAX48U) begin
              lin <= MAX48;
              sat <= 1'b1;
            end else begin
              lin <= $signed(lmag_s[47:0]);
            end
          end else begin
            if (64'(lmag_s) > MAX48U + 64'd1) begin
              lin <= MIN48;
              sat <= 1'b1;
            end else begin
              lin <= -$signed(lmag_s[47:0]);
            end
          end
        end
        S_SUM: begin
          term  <= $signed(sum_sat[47:0]);
          if (sum_sat[48]) sat <= 1'b1;
          state <= S_ACC;
        end
        S_ACC: begin
          acc   <= $signed(acc_sat[47:0]);
          if (acc_sat[48]) sat <= 1'b1;
          state <= S_DONE;
        end
        // emit and clear on the last pair
        S_DONE: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (!o_full) begin
            acc   <= '0;
            sat   <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- src/lj_pair_energy_min_image_sum.sv -----
// Channel  | Handshake         | Payload
// ---------+-------------------+------------------------------------------
// pair in  | push / full       | ref_*, other_*, same_molecule, last_pair
// result   | empty / pop       | energy_sum, saturated
// config   | cfg_valid / ready | cfg_index, cfg_data
//
// Front: takes a new pair only when idle (wrap, square, sum), then a small queue.
// Back: for a pair inside the cutoff, a bit-serial divider and square
// root, then four 64x64 multiplies; the divider is cut short and the multiplies
// skipped when no division is needed (epsilon zero or s^2 out of range);
// a pair outside the cutoff or skipped goes straight to done.
// Synchronous reset clears control state and the energy sum; no sweep.
// A full result queue stalls the back; the front stalls once the pair
// queue is full, and then the input shows full.
module lj_pair_energy_min_image_sum #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] ref_x,
  input  logic signed [31:0] ref_y,
  input  logic signed [31:0] ref_z,
  input  logic signed [31:0] other_x,
  input  logic signed [31:0] other_y,
  input  logic signed [31:0] other_z,
  input  logic               same_molecule,
  input  logic               last_pair,
  output logic               empty,
  input  logic               pop,
  output logic signed [47:0] energy_sum,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import lje_pkg::*;

  cfg_t    cfg;
  logic    mq_wr, mq_full, mq_rd, mq_empty;
  pair_t   mq_in, mq_out;
  logic    oq_wr, oq_full;
  result_t oq_in, oq_out;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_x        <= '0;
      cfg.box_y        <= '0;
      cfg.box_z        <= '0;
      cfg.cutoff       <= '0;
      cfg.sigma_sq     <= SIGMA_SQ_RESET;
      cfg.epsilon      <= EPSILON_RESET;
      cfg.energy_shift <= '0;
      cfg.linear_slope <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BOX_X:        cfg.box_x        <= cfg_data[30:0];
        REG_BOX_Y:        cfg.box_y        <= cfg_data[30:0];
        REG_BOX_Z:        cfg.box_z        <= cfg_data[30:0];
        REG_CUTOFF:       cfg.cutoff       <= cfg_data[30:0];
        REG_SIGMA_SQ:     cfg.sigma_sq     <= cfg_data[62:0];
        REG_EPSILON:      cfg.epsilon      <= cfg_data[31:0];
        REG_ENERGY_SHIFT: cfg.energy_shift <= $signed(cfg_data[47:0]);
        REG_LINEAR_SLOPE: cfg.linear_slope <= $signed(cfg_data[31:0]);
        default: ;
      endcase
    end
  end

  lje_front u_front (
    .clk, .rst, .cfg, .push, .full,
    .ref_x, .ref_y, .ref_z, .other_x, .other_y, .other_z,
    .same_molecule, .last_pair,
    .q_wr(mq_wr), .q_data(mq_in), .q_full(mq_full)
  );

  lje_fifo #(.WIDTH($bits(pair_t)), .DEPTH(QUEUE_DEPTH)) u_pair_q (
    .clk, .rst, .wr_en(mq_wr), .wr_data(mq_in), .full(mq_full),
    .rd_en(mq_rd), .rd_data(mq_out), .empty(mq_empty)
  );

  lje_back u_back (
    .clk, .rst, .cfg,
    .q_empty(mq_empty), .q_data(mq_out), .q_rd(mq_rd),
    .o_wr(oq_wr), .o_data(oq_in), .o_full(oq_full)
  );

  lje_fifo #(.WIDTH($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk, .rst, .wr_en(oq_wr), .wr_data(oq_in), .full(oq_full),
    .rd_en(pop), .rd_data(oq_out), .empty(empty)
  );

  assign energy_sum = $signed(oq_out.energy_sum);
  assign saturated  = oq_out.saturated;
endmodule

// ----- tb/lj_pair_energy_min_image_sum_checker.sv -----
module lj_pair_energy_min_image_sum_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic signed [31:0] ref_x,
  input  logic signed [31:0] ref_y,
  input  logic signed [31:0] ref_z,
  input  logic signed [31:0] other_x,
  input  logic signed [31:0] other_y,
  input  logic signed [31:0] other_z,
  input  logic               same_molecule,
  input  logic               last_pair,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [47:0] energy_sum,
  input  logic               saturated,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  import lje_pkg::*;

  localparam longint E_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint E_MIN = -E_MAX - 1;
  localparam longint FAR   = 64'sd2147483648;

  cfg_t      regs;
  longint    energy_acc;
  logic      sat_seen;
  result_t   sums_due[$];

  initial errors = 0;
  assign pending = sums_due.size();

  // Clamp to the signed 48-bit range, noting saturation
  function automatic longint clamp48(input longint v);
    if (v > E_MAX) begin
      sat_seen = 1'b1;
      return E_MAX;
    end
    if (v < E_MIN) begin
      sat_seen = 1'b1;
      return E_MIN;
    end
    return v;
  endfunction

  // One minimum-image wrap per axis
  function automatic longint wrap_axis(input longint d, input logic [30:0] len);
    longint l;
    l = longint'({33'd0, len});
    if (len != 0) begin
      if (2 * d > l) d = d - l;
      if (2 * d < -l) d = d + l;
    end
    return d;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] trial;
    res = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = res | (64'd1 << i);
      if (trial * trial <= v) res = trial;
    end
    return res;
  endfunction

  // 4*eps*(s^12 - s^6) at the stated truncation points
  function automatic longint lj_energy(input logic [63:0] r2);
    logic [127:0] w;
    logic [63:0]  s2, s4, s6, m, q, v;
    logic         pos;
    if (regs.epsilon == 0) return 0;
    if ({1'b0, regs.sigma_sq} >> 8 >= r2) begin
      sat_seen = 1'b1;
      return E_MAX;
    end
    w  = {65'd0, regs.sigma_sq} << 56;
    s2 = 64'(w / {64'd0, r2});
    w  = {64'd0, s2} * {64'd0, s2};
    s4 = 64'(w >> 72);
    w  = {64'd0, s4} * {64'd0, s2};
    s6 = 64'(w >> 56);
    pos = s6 >= (64'd1 << 40);
    m  = pos ? s6 - (64'd1 << 40) : (64'd1 << 40) - s6;
    w  = {64'd0, s6} * {64'd0, m};
    if ((w >> 120) != 0) begin
      sat_seen = 1'b1;
      return pos ? E_MAX : E_MIN;
    end
    q = 64'(w >> 56);
    w = {64'd0, q} * {96'd0, regs.epsilon};
    if ((w >> 78) != 0) begin
      sat_seen = 1'b1;
      return pos ? E_MAX : E_MIN;
    end
    v = 64'(w >> 14);
    if (pos) begin
      if (v > 64'(E_MAX)) begin
        sat_seen = 1'b1;
        return E_MAX;
      end
      return longint'(v);
    end
    if (v > 64'(E_MAX) + 64'd1) begin
      sat_seen = 1'b1;
      return E_MIN;
    end
    return -longint'(v);
  endfunction

  // slope*(r - cutoff), truncated toward zero
  function automatic longint linear_energy(input logic [63:0] r2);
    longint      diff, slope;
    logic [63:0] mag;
    logic        neg;
    slope = longint'(regs.linear_slope);
    if (slope == 0) return 0;
    diff = longint'(floor_sqrt(r2)) - longint'({33'd0, regs.cutoff});
    mag  = 64'(slope < 0 ? -slope : slope) * 64'(diff < 0 ? -diff : diff);
    mag  = mag >> 8;
    neg  = (slope < 0) != (diff < 0);
    return clamp48(neg ? -longint'(mag) : longint'(mag));
  endfunction

  task automatic accumulate_pair();
    longint      dx, dy, dz, term;
    logic [63:0] r2, cut2;
    result_t     res;
    if (!same_molecule) begin
      dx = wrap_axis(longint'(ref_x) - longint'(other_x), regs.box_x);
      dy = wrap_axis(longint'(ref_y) - longint'(other_y), regs.box_y);
      dz = wrap_axis(longint'(ref_z) - longint'(other_z), regs.box_z);
      if (dx < FAR && dx > -FAR && dy < FAR && dy > -FAR && dz < FAR && dz > -FAR) begin
        r2   = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
        cut2 = 64'(regs.cutoff) * 64'(regs.cutoff);
        if (r2 < cut2) begin
          term = lj_energy(r2) + longint'(regs.energy_shift) + linear_energy(r2);
          term = clamp48(term);
          energy_acc = clamp48(energy_acc + term);
        end
      end
    end
    if (last_pair) begin
      res.energy_sum = energy_acc[47:0];
      res.saturated  = sat_seen;
      sums_due = {sums_due, res};
      energy_acc = 0;
      sat_seen   = 1'b0;
    end
  endtask

  task automatic report(input string what, input longint want, input longint got);
    $display("checker: %s mismatch, expected %0d got %0d", what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      regs              = '0;
      regs.sigma_sq     = SIGMA_SQ_RESET;
      regs.epsilon      = EPSILON_RESET;
      energy_acc        = 0;
      sat_seen          = 1'b0;
      sums_due.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BOX_X:        regs.box_x        = cfg_data[30:0];
          REG_BOX_Y:        regs.box_y        = cfg_data[30:0];
          REG_BOX_Z:        regs.box_z        = cfg_data[30:0];
          REG_CUTOFF:       regs.cutoff       = cfg_data[30:0];
          REG_SIGMA_SQ:     regs.sigma_sq     = cfg_data[62:0];
          REG_EPSILON:      regs.epsilon      = cfg_data[31:0];
          REG_ENERGY_SHIFT: regs.energy_shift = cfg_data[47:0];
          REG_LINEAR_SLOPE: regs.linear_slope = cfg_data[31:0];
          default: ;
        endcase
      end
      // result requests
      if (pop && !empty) begin
        if (sums_due.size() == 0) begin
          report("unexpected result", 0, longint'(energy_sum));
        end else begin
          want = sums_due.pop_front();
          if (energy_sum !== $signed(want.energy_sum))
            report("energy_sum", longint'($signed(want.energy_sum)), longint'(energy_sum));
          if (saturated !== want.saturated)
            report("saturated", want.saturated, saturated);
        end
      end
      // pair requests
      if (push && !full) accumulate_pair();
    end
  end

endmodule

// ----- tb/lj_pair_energy_min_image_sum_tb.sv -----
module lj_pair_energy_min_image_sum_tb;
  import lje_pkg::*;

  localparam int  IDLE_LIMIT = 8000;
  localparam int  SETTLE     = 400;
  localparam int  ONE        = 65536;
  localparam longint E_MAX48 = 64'sh0000_7FFF_FFFF_FFFF;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic signed [31:0] ref_x = '0, ref_y = '0, ref_z = '0;
  logic signed [31:0] other_x = '0, other_y = '0, other_z = '0;
  logic               same_molecule = 1'b0;
  logic               last_pair = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [47:0] energy_sum;
  logic               saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  int                 errors;
  int                 pending;

  int   burst_left = 0;
  bit   gaps_on = 1'b1;
  bit   hold_req = 1'b0;
  int   idle_cycles = 0;

  lj_pair_energy_min_image_sum dut (.*);
  lj_pair_energy_min_image_sum_checker chk (.*);

  always #5 clk = ~clk;

  // Watchdog: cycles with no request moving on any channel
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: pop pattern drawn at random in three modes, long hold-off on request
  initial begin
    int tick, mode;
    tick = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (700) @(posedge clk);
      end
      if (tick % 48 == 0) mode = $urandom_range(0, 2);
      tick++;
      case (mode)
        0:       pop <= 1'b1;
        1:       pop <= $urandom_range(0, 1);
        default: pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Register write; leaves cfg_valid high for the caller to drop
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_regs(input int bx, by, bz, cut, input logic [62:0] sig,
                          input logic [31:0] eps, input longint shift,
                          input logic [31:0] slope);
    write_reg(REG_BOX_X, {33'd0, bx[30:0]});
    write_reg(REG_BOX_Y, {33'd0, by[30:0]});
    write_reg(REG_BOX_Z, {33'd0, bz[30:0]});
    write_reg(REG_CUTOFF, {33'd0, cut[30:0]});
    write_reg(REG_SIGMA_SQ, 64'(sig));
    write_reg(REG_EPSILON, 64'(eps));
    write_reg(REG_ENERGY_SHIFT, 64'(shift));
    write_reg(REG_LINEAR_SLOPE, {32'd0, slope});
    cfg_valid <= 1'b0;
  endtask

  // Offer one pair, in bursts with random gaps between them
  task automatic offer(input logic signed [31:0] rx, ry, rz, ox, oy, oz,
                       input logic sm, lp);
    int gap;
    if (burst_left == 0) begin
      gap = !gaps_on ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 40)
                                                      : $urandom_range(0, 3));
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    ref_x <= rx;  ref_y <= ry;  ref_z <= rz;
    other_x <= ox; other_y <= oy; other_z <= oz;
    same_molecule <= sm;
    last_pair <= lp;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Mostly near pairs, some across the box, some anywhere
  task automatic random_pair(input int span, input int box, input logic lp);
    int r[3], o[3];
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(0, 3) == 0) begin
        r[a] = $urandom;
        o[a] = $urandom;
      end else begin
        r[a] = int'($urandom_range(0, 2097152)) - 1048576;
        o[a] = r[a] + int'($urandom_range(0, 2 * span)) - span;
        if (box != 0 && $urandom_range(0, 4) == 0)
          o[a] = $urandom_range(0, 1) ? o[a] + box : o[a] - box;
      end
    end
    offer(r[0], r[1], r[2], o[0], o[1], o[2], $urandom_range(0, 9) == 0,
          lp | ($urandom_range(0, 7) == 0));
  endtask

  task automatic run_random(input int n, input int span, input int box);
    for (int i = 0; i < n; i++) random_pair(span, box, i == n - 1);
  endtask

  // Drain before touching registers again
  task automatic settle();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int bx, cut;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset registers: cutoff zero, nothing counts
    run_random(20, 3 * ONE, 0);
    settle();

    // reference setting: box 10, cutoff 2.5, sigma 1, eps 1
    set_regs(10 * ONE, 10 * ONE, 10 * ONE, 163840, 63'd1 << 32, ONE,
             -167772, 32'd32768);
    offer(0, 0, 0, 0, 0, 0, 1'b0, 1'b0);                   // coincident: huge s2
    offer(0, 0, 0, 0, 0, 0, 1'b1, 1'b0);                   // same molecule
    offer(ONE, 0, 0, 0, 0, 0, 1'b0, 1'b1);                 // s = 1 exactly
    offer(73562, 0, 0, 0, 0, 0, 1'b0, 1'b0);               // near the minimum
    offer(59000, 0, 0, 0, 0, 0, 1'b0, 1'b0);               // repulsive
    offer(9 * ONE + ONE / 2, 0, 0, 0, 0, 0, 1'b0, 1'b0);   // wraps to -0.5
    offer(0, 0, 0, 9 * ONE, 0, 0, 1'b0, 1'b1);             // wraps to +1.0
    offer(5 * ONE, 0, 0, 0, 0, 0, 1'b0, 1'b0);             // exactly half box
    offer(32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0, 1'b0, 1'b0); // far
    offer(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b0);
    offer(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b1);
    offer(163840, 0, 0, 0, 0, 0, 1'b0, 1'b0);              // on the cutoff
    offer(163839, 0, 0, 0, 0, 0, 1'b0, 1'b0);              // just inside
    offer(0, ONE, 0, 0, 0, 0, 1'b0, 1'b0);
    offer(0, 0, 72000, 0, 0, 0, 1'b0, 1'b0);
    offer(ONE, ONE, ONE, 0, 0, 0, 1'b0, 1'b0);
    offer(0, 0, 0, ONE, 0, 0, 1'b1, 1'b1);                 // skipped, still emits
    run_random(413, 3 * ONE, 10 * ONE);
    settle();

    // top of every register: saturation throughout
    set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, E_MAX48, 32'h7FFF_FFFF);
    run_random(60, 1 << 28, 0);
    settle();

    // bottom: no box, eps zero, most negative shift and slope
    set_regs(0, 0, 0, 10 * ONE, 63'd1, 32'd0, -E_MAX48 - 1, 32'h8000_0000);
    run_random(80, 6 * ONE, 0);
    settle();

    // result side held off while pairs keep coming
    set_regs(8 * ONE, 8 * ONE, 8 * ONE, 3 * ONE, 63'd3 << 31, 2 * ONE, 0, 32'hFFFF_0000);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    run_random(300, 3 * ONE, 8 * ONE);
    gaps_on = 1'b1;
    settle();

    // random settings
    for (int p = 0; p < 5; p++) begin
      bx  = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(2 * ONE, 20 * ONE);
      cut = $urandom_range(ONE / 2, 6 * ONE);
      set_regs(bx, $urandom_range(2 * ONE, 20 * ONE), bx, cut,
               63'($urandom_range(1 << 14, 1 << 18)) << 16,
               $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4 * ONE),
               longint'(int'($urandom_range(0, 1 << 27))) - (1 << 26), $urandom);
      run_random(100, cut + cut / 4, bx);
      settle();
    end

    // cutoff zero again with live parameters
    set_regs(10 * ONE, 10 * ONE, 10 * ONE, 0, 63'd1 << 32, ONE, 12345, 32'd100);
    run_random(60, 2 * ONE, 10 * ONE);
    settle();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- lj_pair_energy_min_image_sum.f -----
src/lje_pkg.sv
src/lje_fifo.sv
src/lje_front.sv
src/lje_back.sv
src/lj_pair_energy_min_image_sum.sv
tb/lj_pair_energy_min_image_sum_checker.sv
tb/lj_pair_energy_min_image_sum_tb.sv
